@@ hw/rtl/word_split_enumerator_core_defines.svh @@
// assertion macros for the word split enumerator checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef WORD_SPLIT_ENUMERATOR_CORE_DEFINES_SVH
`define WORD_SPLIT_ENUMERATOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define WSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("word split enumerator check failed");

// next-cycle implication, off during reset
`define WSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("word split enumerator check failed");

`endif

@@ hw/rtl/wse_pkg.sv @@
// shared types and constants of the word split enumerator
// used by the datapath, the controller and the top level
`default_nettype none

package wse_pkg;

  // fixed field widths of the item ports
  localparam int LEN_W   = 4;
  localparam int IDX_W   = 6;
  localparam int PARTS_W = 3;
  localparam int END_W   = 4;

  // number of end slots in one result item
  localparam int END_SLOTS = 4;

  // parameter defaults
  localparam int DEF_MAX_LEN   = 8;
  localparam int DEF_MAX_PARTS = 4;

  // reset value of the part limit register
  localparam logic [PARTS_W-1:0] MAXP_RESET = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cfg_wr;  // write the part limit register
    logic start;   // take a new word
    logic step;    // emit current split and advance
  } wse_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic len_zero;  // offered word has length zero
    logic last;      // current split is the final one
  } wse_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/wse_datapath.sv @@
// datapath of the word split enumerator: cut registers, advance logic,
// result register; depends on wse_pkg
`default_nettype none

module wse_datapath #(
  parameter int MAX_LEN   = wse_pkg::DEF_MAX_LEN,
  parameter int MAX_PARTS = wse_pkg::DEF_MAX_PARTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wse_pkg::wse_cmd_t           cmd,
  output wse_pkg::wse_status_t             status,
  input  wire logic [wse_pkg::LEN_W-1:0]   in_char_count,
  input  wire logic [wse_pkg::PARTS_W-1:0] cfg_max_parts,
  output logic [wse_pkg::IDX_W-1:0]        out_split_index,
  output logic [wse_pkg::PARTS_W-1:0]      out_part_count,
  output logic [wse_pkg::END_W-1:0]        out_end_first,
  output logic [wse_pkg::END_W-1:0]        out_end_second,
  output logic [wse_pkg::END_W-1:0]        out_end_third,
  output logic [wse_pkg::END_W-1:0]        out_end_fourth,
  output logic                             out_last_split
);
  import wse_pkg::*;

  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int EFF_PARTS = (MAX_PARTS < END_SLOTS) ? MAX_PARTS : END_SLOTS;
  localparam int SLOT_W    = $clog2(END_SLOTS);

  // part limit register
  logic [PARTS_W-1:0] maxp_r;

  // enumeration state
  logic [POS_W-1:0]   len_r;
  logic [PARTS_W-1:0] lim_r;
  logic [PARTS_W-1:0] parts_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [POS_W-1:0]   cut_r   [END_SLOTS];
  logic [POS_W-1:0]   cut_nxt [END_SLOTS];
  logic [POS_W-1:0]   cut_init[END_SLOTS];

  // result register
  logic [IDX_W-1:0]   idx_r;
  logic [PARTS_W-1:0] cnt_parts_r;
  logic [END_W-1:0]   end_r [END_SLOTS];
  logic               last_r;

  logic [POS_W-1:0]   len_sat;
  logic [PARTS_W-1:0] lim_sat;
  logic [SLOT_W-1:0]  pos;
  logic               found;
  logic               more_parts;
  logic               last;
  logic [END_W-1:0]   end_val[END_SLOTS];

  // saturate the word length and the part limit
  always_comb begin
    if (int'(in_char_count) > MAX_LEN) begin
      len_sat = POS_W'(MAX_LEN);
    end else begin
      len_sat = POS_W'(in_char_count);
    end
    if (maxp_r == '0) begin
      lim_sat = PARTS_W'(1);
    end else if (int'(maxp_r) > EFF_PARTS) begin
      lim_sat = PARTS_W'(EFF_PARTS);
    end else begin
      lim_sat = maxp_r;
    end
  end

  // find the rightmost cut that can still move right
  always_comb begin
    int ncuts;
    ncuts = int'(parts_r) - 1;
    found = 1'b0;
    pos   = '0;
    for (int j = 0; j < END_SLOTS; j++) begin
      if (j < ncuts && int'(cut_r[j]) < int'(len_r) - ncuts + j) begin
        found = 1'b1;
        pos   = SLOT_W'(j);
      end
    end
  end

  // next cut set: bump the found cut, pack the rest right after it
  always_comb begin
    for (int j = 0; j < END_SLOTS; j++) begin
      cut_init[j] = POS_W'(j + 1);
      if (j >= int'(pos)) begin
        cut_nxt[j] = POS_W'(int'(cut_r[pos]) + 1 + j - int'(pos));
      end else begin
        cut_nxt[j] = cut_r[j];
      end
    end
  end

  // next part count exists and the end-of-word decision
  assign more_parts = (int'(parts_r) + 1 <= int'(lim_r)) &&
                      (int'(parts_r) + 1 <= int'(len_r));
  assign last = (&cnt_r) || (!found && !more_parts);

  assign status.len_zero = (in_char_count == '0);
  assign status.last     = last;

  // end slot values: unused slots give the word length
  always_comb begin
    for (int j = 0; j < END_SLOTS; j++) begin
      if (j + 1 < int'(parts_r)) begin
        end_val[j] = END_W'(cut_r[j]);
      end else begin
        end_val[j] = END_W'(len_r);
      end
    end
  end

  // part limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxp_r <= MAXP_RESET;
    end else if (cmd.cfg_wr) begin
      maxp_r <= cfg_max_parts;
    end
  end

  // enumeration state update
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r   <= len_sat;
      lim_r   <= lim_sat;
      parts_r <= PARTS_W'(1);
      cnt_r   <= '0;
      cut_r   <= cut_init;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (found) begin
        cut_r <= cut_nxt;
      end else begin
        parts_r <= parts_r + PARTS_W'(1);
        cut_r   <= cut_init;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      idx_r       <= cnt_r;
      cnt_parts_r <= parts_r;
      end_r       <= end_val;
      last_r      <= last;
    end
  end

  assign out_split_index = idx_r;
  assign out_part_count  = cnt_parts_r;
  assign out_end_first   = end_r[0];
  assign out_end_second  = end_r[1];
  assign out_end_third   = end_r[2];
  assign out_end_fourth  = end_r[3];
  assign out_last_split  = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/wse_ctrl.sv @@
// controller of the word split enumerator: state machine and output valid
// depends on wse_pkg
`default_nettype none

module wse_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire wse_pkg::wse_status_t  status,
  output wse_pkg::wse_cmd_t          cmd
);
  import wse_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // output register can take a new item
  assign out_free = !out_valid_r || !out_stall;

  // handshake and command decode
  always_comb begin
    cmd.cfg_wr = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        cmd.start  = in_valid;
        if (in_valid && !status.len_zero) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = out_free;
        if (out_free && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid follows loads and drains
  always_comb begin
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/word_split_enumerator_core.sv @@
// top level of the word split enumerator: controller plus datapath
// depends on wse_pkg, wse_ctrl, wse_datapath
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   in_      | input     | in_valid/in_stall  | char_count
//   out_     | output    | out_valid/out_stall| split_index, part_count, end_*, last
//   cfg_     | input     | cfg_valid/cfg_ready| max_parts
//
// a word is taken while idle, then its splits come out one split per cycle
// from the result register unless out_stall holds a valid item, up to 64 splits
// a word of length zero gives no item
// out_stall with a valid item holds the result register and pauses the enumeration
// rst_n is synchronous; the part limit resets to four
`default_nettype none

module word_split_enumerator_core #(
  parameter int MAX_LEN   = wse_pkg::DEF_MAX_LEN,
  parameter int MAX_PARTS = wse_pkg::DEF_MAX_PARTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [wse_pkg::LEN_W-1:0]   in_char_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [wse_pkg::IDX_W-1:0]        out_split_index,
  output logic [wse_pkg::PARTS_W-1:0]      out_part_count,
  output logic [wse_pkg::END_W-1:0]        out_end_first,
  output logic [wse_pkg::END_W-1:0]        out_end_second,
  output logic [wse_pkg::END_W-1:0]        out_end_third,
  output logic [wse_pkg::END_W-1:0]        out_end_fourth,
  output logic                             out_last_split,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [wse_pkg::PARTS_W-1:0] cfg_max_parts
);
  import wse_pkg::*;

  wse_cmd_t    cmd;
  wse_status_t status;

  // sequencing and handshakes
  wse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // cut enumeration and result register
  wse_datapath #(
    .MAX_LEN   (MAX_LEN),
    .MAX_PARTS (MAX_PARTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_char_count   (in_char_count),
    .cfg_max_parts   (cfg_max_parts),
    .out_split_index (out_split_index),
    .out_part_count  (out_part_count),
    .out_end_first   (out_end_first),
    .out_end_second  (out_end_second),
    .out_end_third   (out_end_third),
    .out_end_fourth  (out_end_fourth),
    .out_last_split  (out_last_split)
  );

endmodule

`default_nettype wire

@@ hw/rtl/wse_checker.sv @@
// port-level checks of the word split enumerator and their bind
// depends on word_split_enumerator_core_defines.svh and wse_pkg
`default_nettype none
`include "word_split_enumerator_core_defines.svh"

module wse_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [wse_pkg::LEN_W-1:0]   in_char_count,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [wse_pkg::IDX_W-1:0]   out_split_index,
  input wire logic [wse_pkg::PARTS_W-1:0] out_part_count,
  input wire logic [wse_pkg::END_W-1:0]   out_end_first,
  input wire logic                        out_last_split
);
  import wse_pkg::*;

  // a nonempty word blocks the input until its splits are out
  `WSE_ASSERT_NXT(a_busy_after_word, in_valid && !in_stall && in_char_count != '0, in_stall)

  // every split has at least one part and a nonempty first part
  `WSE_ASSERT_IMP(a_split_shape, out_valid, out_part_count != '0 && out_end_first != '0)

  // the 64th split always closes the word
  `WSE_ASSERT_IMP(a_limit_last, out_valid && (&out_split_index), out_last_split)

  // a stalled result holds
  `WSE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_split_index) && $stable(out_last_split))

endmodule

bind word_split_enumerator_core wse_checker u_wse_checker (.*);

`default_nettype wire
